[hw/rtl/aatl_pkg.sv]
package aatl_pkg;

  localparam int COORD_INT_BITS  = 12;
  localparam int COORD_FRAC_BITS = 8;
  localparam int MAX_THICKNESS   = 31;

  // Internal fraction bits, coordinate and state widths.
  localparam int QF   = 16;
  localparam int FW   = 20;
  localparam int CW   = COORD_INT_BITS + COORD_FRAC_BITS;
  localparam int QW   = COORD_INT_BITS + QF;
  localparam int SW   = QW + 2;
  localparam int GW   = QF + 2;
  localparam int CLW  = COORD_INT_BITS + 2;
  localparam int XW   = (COORD_INT_BITS + 4 > 15) ? COORD_INT_BITS + 4 : 15;
  localparam int TW   = 5;
  localparam int COLW = 32;
  localparam int COVW = 9;
  localparam int SCRW = 13;
  localparam int PXW  = 14;
  localparam int SLW  = 6;
  localparam int Q_DEPTH = 2;

  localparam logic [QF:0]      ONE  = (QF+1)'(1) << QF;
  localparam logic [QF:0]      HALF = (QF+1)'(1) << (QF - 1);
  localparam logic [COVW-1:0]  COV_FULL = COVW'(256);
  localparam logic [SCRW-1:0]  WIDTH_RESET  = SCRW'(1920);
  localparam logic [SCRW-1:0]  HEIGHT_RESET = SCRW'(1080);

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  typedef enum logic {K_STEP, K_LOAD} kind_e;

  typedef struct packed {
    logic signed [CLW-1:0] col;
    logic signed [CLW-1:0] base;
    logic [COVW-1:0]       ca;
    logic [COVW-1:0]       cb;
  } end_info_t;

  typedef struct packed {
    kind_e                 kind;
    logic                  steep;
    logic signed [GW-1:0]  grad;
    logic signed [SW-1:0]  icpt;
    end_info_t             e0;
    end_info_t             e1;
    logic signed [CLW-1:0] col_now;
    logic signed [CLW-1:0] col_stop;
    logic [TW-1:0]         thick;
    logic [COLW-1:0]       color;
  } qent_t;

  function automatic logic [QW-1:0] to_q(input logic [FW-1:0] v);
    logic [FW+QW-1:0] w;
    w = (FW+QW)'(v);
    return QW'(w[CW-1:0]) << (QF - COORD_FRAC_BITS);
  endfunction

  function automatic logic [COVW-1:0] sat_cov(input logic [COVW:0] v);
    return (v > (COVW+1)'(COV_FULL)) ? COV_FULL : v[COVW-1:0];
  endfunction

endpackage

[hw/rtl/aatl_queue.sv]
module aatl_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  aatl_pkg::qent_t   data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output aatl_pkg::qent_t   data_o
);

  localparam int PW = (aatl_pkg::Q_DEPTH > 1) ? $clog2(aatl_pkg::Q_DEPTH) : 1;
  localparam int NW = $clog2(aatl_pkg::Q_DEPTH + 1);

  aatl_pkg::qent_t mem_q [aatl_pkg::Q_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] cnt_q;

  assign full_o  = (cnt_q == NW'(aatl_pkg::Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(aatl_pkg::Q_DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(aatl_pkg::Q_DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

endmodule

[hw/rtl/aatl_front.sv]
module aatl_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            func_i,
  input  logic [aatl_pkg::FW-1:0]         start_x_i,
  input  logic [aatl_pkg::FW-1:0]         start_y_i,
  input  logic [aatl_pkg::FW-1:0]         end_x_i,
  input  logic [aatl_pkg::FW-1:0]         end_y_i,
  input  logic [aatl_pkg::TW-1:0]         thick_i,
  input  logic [aatl_pkg::COLW-1:0]       color_i,
  output logic                            push_o,
  output aatl_pkg::qent_t                 ent_o,
  input  logic                            full_i
);

  localparam int QW  = aatl_pkg::QW;
  localparam int QF  = aatl_pkg::QF;
  localparam int GW  = aatl_pkg::GW;
  localparam int SW  = aatl_pkg::SW;
  localparam int CLW = aatl_pkg::CLW;
  localparam int NCW = $clog2(QF + 1);
  localparam int PRW = 2 * QF + 2;

  typedef enum logic [3:0] {
    F_IDLE, F_SWAP, F_ORDER, F_DINIT, F_DIV, F_GRAD, F_MUL, F_ADD, F_COV, F_WR, F_PUSH
  } fstate_e;

  fstate_e st_q;
  logic [QW-1:0] x0_q, y0_q, x1_q, y1_q, dx_q, yv_q;
  logic steep_q, neg_q, e_q;
  logic [QW:0] rem_q;
  logic [QF:0] quo_q, xgap_q;
  logic [NCW-1:0] cnt_q;
  logic signed [GW-1:0] grad_q;
  logic signed [2*GW-1:0] p_q;
  logic [aatl_pkg::COORD_INT_BITS:0] xe_q;
  logic signed [SW-1:0] ye_q, icpt_q;
  logic [PRW-1:0] pa_q, pb_q;
  aatl_pkg::end_info_t e0_q, info_w;
  logic [aatl_pkg::TW-1:0] thick_q;
  logic [aatl_pkg::COLW-1:0] color_q;

  logic [QW-1:0] adx_w, ady_w, xs_w;
  logic [QW:0] trial_w, xh_w;
  logic [QF-1:0] fx_w, fr_w;
  logic signed [GW-1:0] d_w, mag_w;
  logic [QF:0] om_w;
  logic accept_w;

  assign accept_w   = in_valid_i && in_ready_o;
  assign in_ready_o = (st_q == F_IDLE) && !full_i;

  assign adx_w   = (x1_q > x0_q) ? x1_q - x0_q : x0_q - x1_q;
  assign ady_w   = (y1_q > y0_q) ? y1_q - y0_q : y0_q - y1_q;
  assign trial_w = (cnt_q == '0) ? rem_q : {rem_q[QW-1:0], 1'b0};
  assign mag_w   = (dx_q == '0) ? GW'(aatl_pkg::ONE) : GW'(quo_q);
  assign xs_w    = e_q ? x1_q : x0_q;
  assign xh_w    = {1'b0, xs_w} + (QW+1)'(aatl_pkg::HALF);
  assign fx_w    = xh_w[QF-1:0];
  assign d_w     = signed'(GW'(aatl_pkg::HALF)) - signed'(GW'(fx_w));
  assign fr_w    = ye_q[QF-1:0];
  assign om_w    = aatl_pkg::ONE - {1'b0, fr_w};

  always_comb begin
    info_w.col  = signed'({1'b0, xe_q});
    info_w.base = ye_q[SW-1:QF];
    info_w.ca   = aatl_pkg::sat_cov(pa_q[PRW-1 -: aatl_pkg::COVW+1]);
    info_w.cb   = aatl_pkg::sat_cov(pb_q[PRW-1 -: aatl_pkg::COVW+1]);
  end

  always_comb begin
    ent_o          = '0;
    ent_o.kind     = (st_q == F_PUSH) ? aatl_pkg::K_LOAD : aatl_pkg::K_STEP;
    ent_o.steep    = steep_q;
    ent_o.grad     = grad_q;
    ent_o.icpt     = icpt_q;
    ent_o.e0       = e0_q;
    ent_o.e1       = info_w;
    ent_o.col_now  = e0_q.col + CLW'(1);
    ent_o.col_stop = info_w.col;
    ent_o.thick    = thick_q;
    ent_o.color    = color_q;
  end

  // The second endpoint is pushed with the load entry from the push state, after the write stage.
  assign push_o = (accept_w && func_i == aatl_pkg::FUNC_STEP) ||
                  (st_q == F_PUSH && !full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= F_IDLE;
    end else begin
      case (st_q)
        F_IDLE: begin
          if (accept_w && func_i == aatl_pkg::FUNC_LOAD) begin
            st_q <= F_SWAP;
          end
        end
        F_SWAP:  st_q <= F_ORDER;
        F_ORDER: st_q <= F_DINIT;
        F_DINIT: st_q <= F_DIV;
        F_DIV: begin
          if (cnt_q == NCW'(QF)) begin
            st_q <= F_GRAD;
          end
        end
        F_GRAD: st_q <= F_MUL;
        F_MUL:  st_q <= F_ADD;
        F_ADD:  st_q <= F_COV;
        F_COV:  st_q <= F_WR;
        F_WR:   st_q <= e_q ? F_PUSH : F_MUL;
        F_PUSH: begin
          if (!full_i) begin
            st_q <= F_IDLE;
          end
        end
        default: st_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      F_IDLE: begin
        x0_q    <= aatl_pkg::to_q(start_x_i);
        y0_q    <= aatl_pkg::to_q(start_y_i);
        x1_q    <= aatl_pkg::to_q(end_x_i);
        y1_q    <= aatl_pkg::to_q(end_y_i);
        thick_q <= (thick_i > aatl_pkg::TW'(aatl_pkg::MAX_THICKNESS)) ?
                   aatl_pkg::TW'(aatl_pkg::MAX_THICKNESS) : thick_i;
        color_q <= color_i;
      end
      F_SWAP: begin
        steep_q <= ady_w > adx_w;
        if (ady_w > adx_w) begin
          x0_q <= y0_q;
          y0_q <= x0_q;
          x1_q <= y1_q;
          y1_q <= x1_q;
        end
      end
      F_ORDER: begin
        if (x0_q > x1_q) begin
          x0_q <= x1_q;
          y0_q <= y1_q;
          x1_q <= x0_q;
          y1_q <= y0_q;
        end
      end
      F_DINIT: begin
        dx_q  <= x1_q - x0_q;
        neg_q <= y1_q < y0_q;
        rem_q <= {1'b0, ady_w};
        quo_q <= '0;
        cnt_q <= '0;
      end
      F_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (trial_w >= {1'b0, dx_q}) begin
          rem_q <= trial_w - {1'b0, dx_q};
          quo_q <= {quo_q[QF-1:0], 1'b1};
        end else begin
          rem_q <= trial_w;
          quo_q <= {quo_q[QF-1:0], 1'b0};
        end
        cnt_q <= cnt_q + NCW'(1);
      end
      F_GRAD: begin
        grad_q <= neg_q ? -mag_w : mag_w;
        e_q    <= 1'b0;
      end
      F_MUL: begin
        p_q    <= grad_q * d_w;
        xe_q   <= xh_w[QW:QF];
        xgap_q <= e_q ? {1'b0, fx_w} : aatl_pkg::ONE - {1'b0, fx_w};
        yv_q   <= e_q ? y1_q : y0_q;
      end
      F_ADD: begin
        ye_q <= signed'({2'b00, yv_q}) + SW'(p_q >>> QF);
      end
      F_COV: begin
        pa_q <= om_w * xgap_q;
        pb_q <= {1'b0, fr_w} * xgap_q;
      end
      F_WR: begin
        if (!e_q) begin
          e0_q   <= info_w;
          icpt_q <= ye_q + SW'(grad_q);
          e_q    <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/aatl_back.sv]
module aatl_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  aatl_pkg::qent_t               ent_i,
  output logic                          pop_o,
  input  logic [aatl_pkg::SCRW-1:0]     width_i,
  input  logic [aatl_pkg::SCRW-1:0]     height_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [aatl_pkg::PXW-1:0]      pixel_x_o,
  output logic [aatl_pkg::PXW-1:0]      pixel_y_o,
  output logic [aatl_pkg::COVW-1:0]     coverage_o,
  output logic [aatl_pkg::COLW-1:0]     color_o,
  output logic                          we_o,
  output logic                          done_o,
  output logic                          last_o
);

  localparam int CLW  = aatl_pkg::CLW;
  localparam int SW   = aatl_pkg::SW;
  localparam int QF   = aatl_pkg::QF;
  localparam int XW   = aatl_pkg::XW;
  localparam int SLW  = aatl_pkg::SLW;
  localparam int COVW = aatl_pkg::COVW;
  localparam int TW   = aatl_pkg::TW;

  typedef enum logic [1:0] {P_IDLE, P_END1, P_END2, P_MID} phase_e;

  phase_e phase_q;
  logic steep_q;
  logic signed [aatl_pkg::GW-1:0] grad_q;
  logic signed [SW-1:0] icpt_q;
  aatl_pkg::end_info_t e0_q, e1_q;
  logic signed [CLW-1:0] now_q, stop_q;
  logic [TW-1:0] thick_q;
  logic [aatl_pkg::COLW-1:0] color_q;

  logic busy_q, mark_q, done_q;
  logic [SLW-1:0] k_q, nsl_q;
  logic [TW-2:0] h_q;
  logic signed [CLW-1:0] col_q, base_q;
  logic [COVW-1:0] ca_q, cb_q;

  logic ov_q, we_q, od_done_q, last_q;
  logic [aatl_pkg::PXW-1:0] px_q, py_q;
  logic [COVW-1:0] cov_q;
  logic [aatl_pkg::COLW-1:0] ocol_q;

  logic adv_w, end2_done_w, mid_done_w, on_w, slot_last_w;
  logic [TW-2:0] h_w;
  logic [QF-1:0] fr_w;
  logic [QF:0] om_w;
  logic signed [XW-1:0] row_w, colx_w, px_w, py_w;
  logic [COVW-1:0] cov_w;

  assign pop_o       = !busy_q && !empty_i;
  assign adv_w       = busy_q && (!ov_q || out_ready_i);
  assign h_w         = thick_q[TW-1:1];
  assign end2_done_w = now_q >= stop_q;
  assign mid_done_w  = (signed'((CLW+1)'(now_q)) + signed'((CLW+1)'(1))) >=
                       signed'((CLW+1)'(stop_q));
  assign fr_w        = icpt_q[QF-1:0];
  assign om_w        = aatl_pkg::ONE - {1'b0, fr_w};
  assign slot_last_w = (k_q == nsl_q);

  // Slot k covers offset k/2 - h, the odd slot one row further down.
  assign row_w  = XW'(base_q) - signed'(XW'(h_q)) + signed'(XW'(k_q[SLW-1:1])) +
                  signed'(XW'(k_q[0]));
  assign colx_w = XW'(col_q);
  assign px_w   = steep_q ? row_w : colx_w;
  assign py_w   = steep_q ? colx_w : row_w;
  assign on_w   = (px_w >= 0) && (px_w < signed'(XW'(width_i))) &&
                  (py_w >= 0) && (py_w < signed'(XW'(height_i)));
  assign cov_w  = k_q[0] ? cb_q : ca_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      steep_q <= 1'b0;
      grad_q  <= '0;
      icpt_q  <= '0;
      now_q   <= '0;
      stop_q  <= '0;
      thick_q <= '0;
      color_q <= '0;
      busy_q  <= 1'b0;
      k_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (pop_o) begin
        if (ent_i.kind == aatl_pkg::K_LOAD) begin
          phase_q <= P_END1;
          steep_q <= ent_i.steep;
          grad_q  <= ent_i.grad;
          icpt_q  <= ent_i.icpt;
          now_q   <= ent_i.col_now;
          stop_q  <= ent_i.col_stop;
          thick_q <= ent_i.thick;
          color_q <= ent_i.color;
        end else begin
          busy_q <= 1'b1;
          k_q    <= '0;
          case (phase_q)
            P_END1: phase_q <= P_END2;
            P_END2: phase_q <= end2_done_w ? P_IDLE : P_MID;
            P_MID: begin
              now_q  <= now_q + CLW'(1);
              icpt_q <= icpt_q + SW'(grad_q);
              if (mid_done_w) begin
                phase_q <= P_IDLE;
              end
            end
            default: phase_q <= P_IDLE;
          endcase
        end
      end
      if (adv_w) begin
        k_q <= k_q + SLW'(1);
        if (slot_last_w) begin
          busy_q <= 1'b0;
        end
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && ent_i.kind == aatl_pkg::K_LOAD) begin
      e0_q <= ent_i.e0;
      e1_q <= ent_i.e1;
    end
    if (pop_o && ent_i.kind == aatl_pkg::K_STEP) begin
      h_q    <= h_w;
      mark_q <= (phase_q == P_IDLE);
      nsl_q  <= (phase_q == P_IDLE) ? '0 : {h_w, 2'b01};
      case (phase_q)
        P_END1: begin
          col_q  <= e0_q.col;
          base_q <= e0_q.base;
          ca_q   <= e0_q.ca;
          cb_q   <= e0_q.cb;
          done_q <= 1'b0;
        end
        P_END2: begin
          col_q  <= e1_q.col;
          base_q <= e1_q.base;
          ca_q   <= e1_q.ca;
          cb_q   <= e1_q.cb;
          done_q <= end2_done_w;
        end
        P_MID: begin
          col_q  <= now_q;
          base_q <= icpt_q[SW-1:QF];
          ca_q   <= om_w[QF -: COVW];
          cb_q   <= COVW'(fr_w[QF-1:8]);
          done_q <= mid_done_w;
        end
        default: begin
          col_q  <= '0;
          base_q <= '0;
          ca_q   <= '0;
          cb_q   <= '0;
          done_q <= 1'b1;
        end
      endcase
    end
    if (adv_w) begin
      if (mark_q) begin
        px_q   <= '0;
        py_q   <= '0;
        cov_q  <= '0;
        ocol_q <= '0;
        we_q   <= 1'b0;
      end else begin
        px_q   <= px_w[aatl_pkg::PXW-1:0];
        py_q   <= py_w[aatl_pkg::PXW-1:0];
        cov_q  <= cov_w;
        ocol_q <= color_q;
        we_q   <= on_w && (cov_w != '0);
      end
      od_done_q <= done_q;
      last_q    <= slot_last_w;
    end
  end

  assign out_valid_o = ov_q;
  assign pixel_x_o   = px_q;
  assign pixel_y_o   = py_q;
  assign coverage_o  = cov_q;
  assign color_o     = ocol_q;
  assign we_o        = we_q;
  assign done_o      = od_done_q;
  assign last_o      = last_q;

`ifndef SYNTH
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (k_q <= nsl_q))
    else $error("slot counter ran past the column");
  a_we_cov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && we_q) |-> (cov_q != '0))
    else $error("write enabled with zero coverage");
  a_load_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && ent_i.kind == aatl_pkg::K_LOAD) |=> (phase_q == P_END1))
    else $error("load did not arm the first endpoint");
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_w && mark_q) |=> (last_q && od_done_q))
    else $error("done marker not a single final word");
`endif

endmodule

[hw/rtl/antialiased_thick_line_raster.sv]
// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata: line fields, tuser: func
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata: plot fields, tuser, tlast
// cfg       in         cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i
//
// A step word emits 2*(2*floor(T/2)+1) plot words, one per cycle unless m_axis
// stalls; a step with no line loaded emits a single done marker. A load word
// holds the front end busy after it is accepted, through the bit-serial
// gradient divider and the two endpoint passes. Reset clears the state
// machines, queue pointers and valid flags; screen size resets to 1920x1080.
// Steps queue behind a load and either side may stall on its own.
module antialiased_thick_line_raster (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // start_x[19:0], start_y[39:20], end_x[59:40], end_y[79:60],
  // line_thickness[84:80], line_color[116:85]
  input  logic [119:0] s_axis_tdata,
  // func[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pixel_x[13:0], pixel_y[27:14], coverage[36:28], pixel_color[68:37],
  // write_enable[69]
  output logic [71:0]  m_axis_tdata,
  // line_done[0]
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [12:0]  cfg_data_i
);

  logic [aatl_pkg::SCRW-1:0] width_q, height_q;
  logic push_w, full_w, pop_w, empty_w;
  aatl_pkg::qent_t push_ent_w, head_ent_w;
  logic [aatl_pkg::PXW-1:0] px_w, py_w;
  logic [aatl_pkg::COVW-1:0] cov_w;
  logic [aatl_pkg::COLW-1:0] col_w;
  logic we_w;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= aatl_pkg::WIDTH_RESET;
      height_q <= aatl_pkg::HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        aatl_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
        aatl_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  aatl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .func_i     (s_axis_tuser),
    .start_x_i  (s_axis_tdata[19:0]),
    .start_y_i  (s_axis_tdata[39:20]),
    .end_x_i    (s_axis_tdata[59:40]),
    .end_y_i    (s_axis_tdata[79:60]),
    .thick_i    (s_axis_tdata[84:80]),
    .color_i    (s_axis_tdata[116:85]),
    .push_o     (push_w),
    .ent_o      (push_ent_w),
    .full_i     (full_w)
  );

  aatl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_w),
    .data_i  (push_ent_w),
    .full_o  (full_w),
    .pop_i   (pop_w),
    .empty_o (empty_w),
    .data_o  (head_ent_w)
  );

  aatl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty_w),
    .ent_i       (head_ent_w),
    .pop_o       (pop_w),
    .width_i     (width_q),
    .height_i    (height_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .pixel_x_o   (px_w),
    .pixel_y_o   (py_w),
    .coverage_o  (cov_w),
    .color_o     (col_w),
    .we_o        (we_w),
    .done_o      (m_axis_tuser),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, we_w, col_w, cov_w, py_w, px_w};

endmodule
